@@ hw/rtl/adrp_pair_pattern_detector_core_assert.svh @@
// Assertion macros used by the ADRP pair detector checker.
`ifndef ADRP_PAIR_PATTERN_DETECTOR_CORE_ASSERT_SVH
`define ADRP_PAIR_PATTERN_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define ADRP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("adrp assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ADRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("adrp assertion failed");

`endif

@@ hw/rtl/adrp_pkg.sv @@
// Package: widths, opcode masks, register map and shared types of the ADRP pair detector.
`timescale 1ns / 1ps
package adrp_pkg;

  localparam int WORD_W = 32;
  localparam int ADDR_W = 64;
  localparam int REG_W  = 5;
  localparam int MAXW_CFG_W = 13;
  localparam int MAXM_CFG_W = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int MAX_WORDS_DEF   = 4096;
  localparam int MAX_MATCHES_DEF = 64;

  localparam logic [MAXW_CFG_W-1:0] MAXW_RESET = 13'd4096;
  localparam logic [MAXM_CFG_W-1:0] MAXM_RESET = 7'd64;

  // Register index taken from paddr[2]
  localparam logic REG_MAX_WORDS   = 1'b0;
  localparam logic REG_MAX_MATCHES = 1'b1;

  // Opcode masks and patterns
  localparam logic [WORD_W-1:0] ADRP_MASK = 32'h9F00_0000;
  localparam logic [WORD_W-1:0] ADRP_OP   = 32'h9000_0000;
  localparam logic [WORD_W-1:0] SEC_MASK  = 32'hFFC0_0000;
  localparam logic [WORD_W-1:0] ADD_OP    = 32'h9100_0000;
  localparam logic [WORD_W-1:0] LDR_OP    = 32'hF940_0000;
  localparam logic [WORD_W-1:0] BR_MASK   = 32'hFC00_0000;
  localparam logic [WORD_W-1:0] B_OP      = 32'h1400_0000;
  localparam logic [WORD_W-1:0] BL_OP     = 32'h9400_0000;

  // Second word kind
  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_LDR = 1'b1;

  // Branch kind codes
  localparam logic [1:0] BR_NONE = 2'd0;
  localparam logic [1:0] BR_B    = 2'd1;
  localparam logic [1:0] BR_BL   = 2'd2;

  // Two older words of the window
  typedef struct packed {
    logic [WORD_W-1:0] oldest_word;
    logic [WORD_W-1:0] middle_word;
    logic [ADDR_W-1:0] oldest_address;
  } window_t;

  // Decoded pattern and the result fields it forms
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] match_address;
    logic [ADDR_W-1:0] resolved_target;
    logic [REG_W-1:0]  dest_register;
    logic              second_kind;
    logic [1:0]        branch_kind;
    logic [ADDR_W-1:0] branch_target;
  } match_t;

endpackage

@@ hw/rtl/adrp_if.sv @@
// Interfaces: instruction word channel and match result channel.
`timescale 1ns / 1ps
interface adrp_in_if;
  import adrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] insn_word;
  logic [ADDR_W-1:0] insn_address;
  logic              new_scan;

  modport source(output valid, insn_word, insn_address, new_scan, input ready);
  modport sink(input valid, insn_word, insn_address, new_scan, output ready);
endinterface

interface adrp_out_if;
  import adrp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] match_address;
  logic [ADDR_W-1:0] resolved_target;
  logic [REG_W-1:0]  dest_register;
  logic              second_kind;
  logic [1:0]        branch_kind;
  logic [ADDR_W-1:0] branch_target;

  modport source(output valid, match_address, resolved_target, dest_register,
                 second_kind, branch_kind, branch_target, input ready);
  modport sink(input valid, match_address, resolved_target, dest_register,
               second_kind, branch_kind, branch_target, output ready);
endinterface

@@ hw/rtl/adrp_cfg_regs.sv @@
// APB register file holding the word and match limits.
`timescale 1ns / 1ps
module adrp_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [adrp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [adrp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [adrp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [adrp_pkg::MAXW_CFG_W-1:0]    max_words_o,
  output logic [adrp_pkg::MAXM_CFG_W-1:0]    max_matches_o
);
  import adrp_pkg::*;

  logic                  wr_en;
  logic                  reg_sel;
  logic [MAXW_CFG_W-1:0] max_words_q;
  logic [MAXM_CFG_W-1:0] max_matches_q;

  // Word index; byte lanes within a word are ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Write registers in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_words_q   <= MAXW_RESET;
      max_matches_q <= MAXM_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_WORDS:   max_words_q   <= pwdata[MAXW_CFG_W-1:0];
        REG_MAX_MATCHES: max_matches_q <= pwdata[MAXM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back selected register
  always_comb begin
    case (reg_sel)
      REG_MAX_WORDS:   prdata = {{(APB_DATA_W-MAXW_CFG_W){1'b0}}, max_words_q};
      REG_MAX_MATCHES: prdata = {{(APB_DATA_W-MAXM_CFG_W){1'b0}}, max_matches_q};
      default:         prdata = '0;
    endcase
  end

  assign max_words_o   = max_words_q;
  assign max_matches_o = max_matches_q;

endmodule

@@ hw/rtl/adrp_match_dec.sv @@
// Pattern decoder: ADRP + ADD/LDR pair test, address forming and branch target.
`timescale 1ns / 1ps
module adrp_match_dec (
  input  adrp_pkg::window_t             win_i,
  input  logic [adrp_pkg::WORD_W-1:0]   third_word_i,
  input  logic [adrp_pkg::ADDR_W-1:0]   third_address_i,
  output adrp_pkg::match_t              match_o
);
  import adrp_pkg::*;

  logic [WORD_W-1:0] adrp;
  logic [WORD_W-1:0] sec;
  logic [REG_W-1:0]  rd;
  logic              is_adrp;
  logic              is_add;
  logic              is_ldr;
  logic              regs_ok;
  logic [11:0]       imm12;
  logic [14:0]       off;
  logic [20:0]       page_imm;
  logic [51:0]       page_hi;
  logic [WORD_W-1:0] br_op;
  logic [25:0]       imm26;

  assign adrp = win_i.oldest_word;
  assign sec  = win_i.middle_word;
  assign rd   = adrp[REG_W-1:0];

  // Classify the two older words
  assign is_adrp = (adrp & ADRP_MASK) == ADRP_OP;
  assign is_add  = (sec & SEC_MASK) == ADD_OP;
  assign is_ldr  = (sec & SEC_MASK) == LDR_OP;
  assign regs_ok = (sec[9:5] == rd) && (sec[4:0] == rd);

  // Offset: LDR scales by 8
  assign imm12 = sec[21:10];
  assign off   = is_ldr ? {imm12, 3'b000} : {3'b000, imm12};

  // Page base plus signed page offset, offset carry folded in above bit 12
  assign page_imm = {adrp[23:5], adrp[30:29]};
  assign page_hi  = win_i.oldest_address[63:12] + {{31{page_imm[20]}}, page_imm}
                    + {49'd0, off[14:12]};

  // Branch in the newest word
  assign br_op = third_word_i & BR_MASK;
  assign imm26 = third_word_i[25:0];

  always_comb begin
    match_o.hit             = is_adrp && (is_add || is_ldr) && regs_ok;
    match_o.match_address   = win_i.oldest_address;
    match_o.resolved_target = {page_hi, off[11:0]};
    match_o.dest_register   = rd;
    match_o.second_kind     = is_ldr ? KIND_LDR : KIND_ADD;
    match_o.branch_kind     = BR_NONE;
    match_o.branch_target   = '0;
    if (br_op == B_OP || br_op == BL_OP) begin
      match_o.branch_kind   = (br_op == B_OP) ? BR_B : BR_BL;
      match_o.branch_target = third_address_i + {{36{imm26[25]}}, imm26, 2'b00};
    end
  end

endmodule

@@ hw/rtl/adrp_scan_ctrl.sv @@
// Scan control: three-word window, word and match counters, limit checks.
`timescale 1ns / 1ps
module adrp_scan_ctrl #(
  parameter int MAX_WORDS   = adrp_pkg::MAX_WORDS_DEF,
  parameter int MAX_MATCHES = adrp_pkg::MAX_MATCHES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [adrp_pkg::WORD_W-1:0]     insn_word_i,
  input  logic [adrp_pkg::ADDR_W-1:0]     insn_address_i,
  input  logic                            new_scan_i,
  input  logic [adrp_pkg::MAXW_CFG_W-1:0] max_words_i,
  input  logic [adrp_pkg::MAXM_CFG_W-1:0] max_matches_i,
  input  logic                            hit_i,
  output adrp_pkg::window_t               win_o,
  output logic                            emit_o
);
  import adrp_pkg::*;

  localparam int WCW   = $clog2(MAX_WORDS + 1);
  localparam int MCW   = $clog2(MAX_MATCHES + 1);
  localparam int WCMPW = (WCW > MAXW_CFG_W) ? WCW : MAXW_CFG_W;
  localparam int MCMPW = (MCW > MAXM_CFG_W) ? MCW : MAXM_CFG_W;

  logic [WORD_W-1:0] oldest_word_q, middle_word_q;
  logic [ADDR_W-1:0] oldest_address_q, middle_address_q;
  logic [1:0]        fill_q, fill_eff;
  logic [WCW-1:0]    words_q, words_eff;
  logic [MCW-1:0]    matches_q, matches_eff;
  logic [WCMPW-1:0]  word_limit, words_cfg;
  logic [MCMPW-1:0]  match_limit, matches_cfg;
  logic              taken;
  logic              full;
  logic              under_limit;

  // Effective limits: the smaller of register and build size
  assign words_cfg   = WCMPW'(max_words_i);
  assign matches_cfg = MCMPW'(max_matches_i);
  assign word_limit  = (words_cfg < WCMPW'(MAX_WORDS)) ? words_cfg : WCMPW'(MAX_WORDS);
  assign match_limit = (matches_cfg < MCMPW'(MAX_MATCHES)) ? matches_cfg
                                                            : MCMPW'(MAX_MATCHES);

  // Counts as seen after an optional scan restart
  assign fill_eff    = new_scan_i ? 2'd0 : fill_q;
  assign words_eff   = new_scan_i ? '0 : words_q;
  assign matches_eff = new_scan_i ? '0 : matches_q;

  assign taken       = WCMPW'(words_eff) < word_limit;
  assign full        = fill_eff == 2'd2;
  assign under_limit = MCMPW'(matches_eff) < match_limit;
  assign emit_o      = advance_i && taken && full && under_limit && hit_i;

  // Advance counters on each beat taken under the word limit; a new scan clears them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 2'd0;
      words_q   <= '0;
      matches_q <= '0;
    end else if (advance_i) begin
      fill_q    <= fill_eff;
      words_q   <= words_eff;
      matches_q <= matches_eff;
      if (taken) begin
        words_q <= words_eff + 1'b1;
        if (!full) begin
          fill_q <= fill_eff + 2'd1;
        end
        if (emit_o) begin
          matches_q <= matches_eff + 1'b1;
        end
      end
    end
  end

  // Shift the window; contents are gated by the fill count
  always_ff @(posedge clk_i) begin
    if (advance_i && taken) begin
      oldest_word_q    <= middle_word_q;
      oldest_address_q <= middle_address_q;
      middle_word_q    <= insn_word_i;
      middle_address_q <= insn_address_i;
    end
  end

  assign win_o.oldest_word    = oldest_word_q;
  assign win_o.middle_word    = middle_word_q;
  assign win_o.oldest_address = oldest_address_q;

endmodule

@@ hw/rtl/adrp_pair_pattern_detector_core.sv @@
// Pipeline: an accepted beat is held in the input register and decoded there; its
// match is registered in the result register. Throughput: one instruction word per
// cycle unless the output stalls; the window and counters update in the single
// decode stage, and the result register frees as soon as the sink takes a beat.
// Reset: asynchronous active low; clears valid flags, window fill and scan counters,
// and loads the word limit to 4096 and the match limit to 64.
`timescale 1ns / 1ps
module adrp_pair_pattern_detector_core #(
  parameter int MAX_WORDS   = adrp_pkg::MAX_WORDS_DEF,
  parameter int MAX_MATCHES = adrp_pkg::MAX_MATCHES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  adrp_in_if.sink                         in_i,
  adrp_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [adrp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [adrp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [adrp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import adrp_pkg::*;

  logic [MAXW_CFG_W-1:0] max_words;
  logic [MAXM_CFG_W-1:0] max_matches;

  logic              s1_valid_q;
  logic [WORD_W-1:0] s1_word_q;
  logic [ADDR_W-1:0] s1_address_q;
  logic              s1_new_scan_q;
  logic              out_free;
  logic              advance;
  logic              emit;
  window_t           win;
  match_t            match;
  match_t            res_q;
  logic              res_valid_q;

  adrp_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_words_o   (max_words),
    .max_matches_o (max_matches)
  );

  // Handshake: result register frees when empty or being drained
  assign out_free = !res_valid_q || out_o.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_word_q     <= in_i.insn_word;
      s1_address_q  <= in_i.insn_address;
      s1_new_scan_q <= in_i.new_scan;
    end
  end

  adrp_scan_ctrl #(
    .MAX_WORDS   (MAX_WORDS),
    .MAX_MATCHES (MAX_MATCHES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .insn_word_i    (s1_word_q),
    .insn_address_i (s1_address_q),
    .new_scan_i     (s1_new_scan_q),
    .max_words_i    (max_words),
    .max_matches_i  (max_matches),
    .hit_i          (match.hit),
    .win_o          (win),
    .emit_o         (emit)
  );

  adrp_match_dec u_dec (
    .win_i           (win),
    .third_word_i    (s1_word_q),
    .third_address_i (s1_address_q),
    .match_o         (match)
  );

  // Result register: drain on take, load on a match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (emit) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= match;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.match_address   = res_q.match_address;
  assign out_o.resolved_target = res_q.resolved_target;
  assign out_o.dest_register   = res_q.dest_register;
  assign out_o.second_kind     = res_q.second_kind;
  assign out_o.branch_kind     = res_q.branch_kind;
  assign out_o.branch_target   = res_q.branch_target;

endmodule

@@ hw/rtl/adrp_chk.sv @@
// Port checker for the ADRP pair detector, bound to the top level.
`timescale 1ns / 1ps
`include "adrp_pair_pattern_detector_core_assert.svh"
module adrp_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [adrp_pkg::ADDR_W-1:0]   match_address_i,
  input logic [adrp_pkg::ADDR_W-1:0]   resolved_target_i,
  input logic [adrp_pkg::REG_W-1:0]    dest_register_i,
  input logic                          second_kind_i,
  input logic [1:0]                    branch_kind_i,
  input logic [adrp_pkg::ADDR_W-1:0]   branch_target_i
);
  import adrp_pkg::*;

  // Hold a stalled result beat unchanged
  `ADRP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(match_address_i) && $stable(resolved_target_i) && $stable(dest_register_i) && $stable(second_kind_i) && $stable(branch_kind_i) && $stable(branch_target_i))

  // Branch kind is one of the three codes
  `ADRP_ASSERT_IMPLY(a_bkind, clk_i, rst_ni, out_valid_i, branch_kind_i == BR_NONE || branch_kind_i == BR_B || branch_kind_i == BR_BL)

  // No branch means a zero target
  `ADRP_ASSERT_IMPLY(a_btarget_zero, clk_i, rst_ni, out_valid_i && branch_kind_i == BR_NONE, branch_target_i == '0)

  // LDR forms an 8-byte aligned offset on a page base
  `ADRP_ASSERT_IMPLY(a_ldr_align, clk_i, rst_ni, out_valid_i && second_kind_i == KIND_LDR, resolved_target_i[2:0] == 3'b000)

endmodule

bind adrp_pair_pattern_detector_core adrp_chk u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .match_address_i   (out_o.match_address),
  .resolved_target_i (out_o.resolved_target),
  .dest_register_i   (out_o.dest_register),
  .second_kind_i     (out_o.second_kind),
  .branch_kind_i     (out_o.branch_kind),
  .branch_target_i   (out_o.branch_target)
);
